// ----- hdl/gbi_pkg.sv -----
// shared types and constants of the grid bilinear interpolator
`default_nettype none

package gbi_pkg;

    // grid size defaults
    localparam int MAX_ROWS_DEF = 64;
    localparam int MAX_COLS_DEF = 64;

    // field widths
    localparam int DATA_W     = 32;
    localparam int IDX_W      = 6;
    localparam int CNT_W      = 7;
    localparam int CFG_IDX_W  = 3;
    localparam int FRAC_W     = 16;
    localparam int S_TDATA_W  = 112;
    localparam int M_TDATA_W  = 32;

    // shared multiplier and accumulator widths
    localparam int MUL_A_W = 34;
    localparam int MUL_B_W = 33;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;
    localparam int ACC_W   = PROD_W;
    localparam int OFS_W   = 33;
    localparam int RES_W   = 36;

    // weight of one full grid step in Q1.16
    localparam logic [FRAC_W:0] ONE_Q16 = 17'h10000;

    // command codes
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_X_ORIGIN   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_X_END      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_X_INV_STEP = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_Y_ORIGIN   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_Y_END      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_Y_INV_STEP = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_ROWS_USED  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_COLS_USED  = 3'd7;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RANGE,
        ST_TX,
        ST_TY,
        ST_WGT,
        ST_CELL,
        ST_SUM,
        ST_RND,
        ST_OUT
    } gbi_state_t;

    typedef struct packed {
        logic acc_clr;
        logic acc_add;
    } gbi_mac_ctrl_t;

endpackage

`default_nettype wire

// ----- hdl/gbi_mac.sv -----
// shared signed multiplier with registered product and accumulator
`default_nettype none

module gbi_mac (
    input  wire logic                                aclk,
    input  wire gbi_pkg::gbi_mac_ctrl_t              ctrl,
    input  wire logic signed [gbi_pkg::MUL_A_W-1:0]  op_a,
    input  wire logic signed [gbi_pkg::MUL_B_W-1:0]  op_b,
    output logic signed [gbi_pkg::PROD_W-1:0]        prod,
    output logic signed [gbi_pkg::ACC_W-1:0]         acc
);

    logic signed [gbi_pkg::PROD_W-1:0] prod_reg;
    logic signed [gbi_pkg::ACC_W-1:0]  acc_reg;
    logic signed [gbi_pkg::ACC_W-1:0]  acc_next;

    always_comb begin
        if (ctrl.acc_clr) begin
            acc_next = '0;
        end else if (ctrl.acc_add) begin
            acc_next = acc_reg + prod_reg;
        end else begin
            acc_next = acc_reg;
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg <= op_a * op_b;
        acc_reg  <= acc_next;
    end

    assign prod = prod_reg;
    assign acc  = acc_reg;

endmodule

`default_nettype wire

// ----- hdl/grid_bilinear_interpolator.sv -----
// top level: grid store, query sequencer and result register
`default_nettype none

// Holds a MAX_ROWS x MAX_COLS grid of signed Q16.16 samples and answers (x, y)
// queries with bilinear interpolation, saturated to 32 bits. An input transfer
// with tuser 0 writes one grid entry; tuser 1 is a query.
// A query keeps s_tready low until its result has moved into the output
// register, which waits for the previous result to leave it. The query is
// slow because one multiplier serves the coordinate scaling, the four corner
// weights and the four corner products in turn, and the single-port grid
// memory gives one corner per read. A query whose y lies outside the grid
// interpolates along x on the first or last column and adds the y offset.
// Reading a grid entry in use that was never written gives an undefined
// result. Configuration writes are taken at any time but belong to idle
// periods.

module grid_bilinear_interpolator #(
    parameter int MAX_ROWS = gbi_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLS = gbi_pkg::MAX_COLS_DEF
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // config write channel
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [gbi_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [gbi_pkg::DATA_W-1:0]        cfg_data,
    // input stream
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // row[5:0], col[11:6], sample[43:12], x_coord[75:44], y_coord[107:76], zeros
    input  wire logic [gbi_pkg::S_TDATA_W-1:0]     s_tdata,
    // cmd[0]
    input  wire logic                              s_tuser,
    // result stream
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // value[31:0]
    output logic [gbi_pkg::M_TDATA_W-1:0]          m_tdata,
    // saturated[0]
    output logic                                   m_tuser
);

    localparam int DEPTH = MAX_ROWS * MAX_COLS;
    localparam int AW    = $clog2(DEPTH);
    localparam int RW    = $clog2(MAX_ROWS);
    localparam int CW    = $clog2(MAX_COLS);

    localparam int DW = gbi_pkg::DATA_W;
    localparam int FW = gbi_pkg::FRAC_W;

    // config registers
    logic signed [DW-1:0]              x_origin_reg, x_end_reg, y_origin_reg, y_end_reg;
    logic [DW-1:0]                     x_inv_step_reg, y_inv_step_reg;
    logic [gbi_pkg::CNT_W-1:0]         rows_used_reg, cols_used_reg;

    gbi_pkg::gbi_state_t state_reg, state_next;

    // query datapath
    logic signed [DW-1:0]              x_reg, y_reg;
    logic                              y_lo_reg, y_hi_reg;
    logic [DW-1:0]                     i_reg, j_reg;
    logic [FW-1:0]                     dt_reg, ds_reg;
    logic signed [gbi_pkg::OFS_W-1:0]  offset_reg;
    logic signed [gbi_pkg::RES_W-1:0]  res_reg;
    logic [1:0]                        k_reg;
    logic                              cell_ok_reg;
    logic signed [DW-1:0]              rd_reg;

    // result register
    logic                              m_valid_reg;
    logic [DW-1:0]                     m_value_reg;
    logic                              m_sat_reg;

    logic [DW-1:0] mem [DEPTH];

    // unpacked input fields
    logic                              in_cmd;
    logic [gbi_pkg::IDX_W-1:0]         in_row, in_col;
    logic [DW-1:0]                     in_sample;
    logic signed [DW-1:0]              in_x, in_y;

    assign in_cmd    = s_tuser;
    assign in_row    = s_tdata[5:0];
    assign in_col    = s_tdata[11:6];
    assign in_sample = s_tdata[43:12];
    assign in_x      = s_tdata[75:44];
    assign in_y      = s_tdata[107:76];

    // combinational helpers
    logic                              s_acc;
    logic                              wr_ok;
    logic [AW-1:0]                     wr_addr;
    logic                              x_in, y_lo, y_hi, y_out;
    logic signed [DW:0]                dx, dy, y_ofs;
    logic [DW-1:0]                     j_hi;
    logic                              di, dj;
    logic [DW:0]                       ri, cj;
    logic                              corner_ok;
    logic [AW-1:0]                     rd_addr;
    logic [FW:0]                       wx, wy;
    logic signed [gbi_pkg::RES_W-1:0]  res_sum;
    logic                              sat_hi, sat_lo;
    logic                              out_free;

    gbi_pkg::gbi_mac_ctrl_t                mac_ctrl;
    logic signed [gbi_pkg::MUL_A_W-1:0]    op_a;
    logic signed [gbi_pkg::MUL_B_W-1:0]    op_b;
    logic signed [gbi_pkg::PROD_W-1:0]     prod;
    logic signed [gbi_pkg::ACC_W-1:0]      acc;

    gbi_mac u_mac (
        .aclk (aclk),
        .ctrl (mac_ctrl),
        .op_a (op_a),
        .op_b (op_b),
        .prod (prod),
        .acc  (acc)
    );

    assign cfg_ready = 1'b1;
    assign s_acc     = s_tvalid && s_tready;
    assign out_free  = !m_valid_reg || m_tready;

    assign wr_ok   = (32'(in_row) < 32'(MAX_ROWS)) && (32'(in_col) < 32'(MAX_COLS));
    assign wr_addr = AW'(32'(in_row) * 32'(MAX_COLS) + 32'(in_col));

    assign x_in  = (x_reg >= x_origin_reg) && (x_reg <= x_end_reg);
    assign y_lo  = y_reg < y_origin_reg;
    assign y_hi  = y_reg > y_end_reg;
    assign y_out = y_lo_reg || y_hi_reg;
    assign dx    = {x_reg[DW-1], x_reg} - {x_origin_reg[DW-1], x_origin_reg};
    assign dy    = {y_reg[DW-1], y_reg} - {y_origin_reg[DW-1], y_origin_reg};
    assign y_ofs = y_lo_reg ? dy : ({y_reg[DW-1], y_reg} - {y_end_reg[DW-1], y_end_reg});

    // last column in use; wraps to all ones for zero columns, which never reads
    assign j_hi = (32'(cols_used_reg) > 32'(MAX_COLS)) ? DW'(MAX_COLS - 1)
                                                       : (32'(cols_used_reg) - 32'd1);

    // corner k: bit 1 steps along x, bit 0 along y
    assign di = k_reg[1];
    assign dj = k_reg[0];
    assign ri = {1'b0, i_reg} + 33'(di);
    assign cj = {1'b0, j_reg} + 33'(dj);
    assign corner_ok = (ri < 33'(rows_used_reg)) && (ri < 33'(MAX_ROWS))
                    && (cj < 33'(cols_used_reg)) && (cj < 33'(MAX_COLS))
                    && !(y_out && dj);
    assign rd_addr = AW'(32'(ri[RW-1:0]) * 32'(MAX_COLS) + 32'(cj[CW-1:0]));

    assign wx = di ? {1'b0, dt_reg} : (gbi_pkg::ONE_Q16 - {1'b0, dt_reg});
    assign wy = dj ? {1'b0, ds_reg} : (gbi_pkg::ONE_Q16 - {1'b0, ds_reg});

    // round to nearest with ties up, then add the y offset
    assign res_sum = gbi_pkg::RES_W'($signed(acc[gbi_pkg::ACC_W-1:32]))
                   + gbi_pkg::RES_W'({1'b0, acc[31]})
                   + gbi_pkg::RES_W'(offset_reg);
    assign sat_hi = res_reg > 36'sd2147483647;
    assign sat_lo = res_reg < -36'sd2147483648;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            gbi_pkg::ST_IDLE: begin
                if (s_acc && in_cmd == gbi_pkg::CMD_QUERY) begin
                    state_next = gbi_pkg::ST_RANGE;
                end
            end
            gbi_pkg::ST_RANGE: begin
                state_next = x_in ? gbi_pkg::ST_TX : gbi_pkg::ST_OUT;
            end
            gbi_pkg::ST_TX:   state_next = gbi_pkg::ST_TY;
            gbi_pkg::ST_TY:   state_next = gbi_pkg::ST_WGT;
            gbi_pkg::ST_WGT:  state_next = gbi_pkg::ST_CELL;
            gbi_pkg::ST_CELL: begin
                state_next = (k_reg == 2'd3) ? gbi_pkg::ST_SUM : gbi_pkg::ST_WGT;
            end
            gbi_pkg::ST_SUM:  state_next = gbi_pkg::ST_RND;
            gbi_pkg::ST_RND:  state_next = gbi_pkg::ST_OUT;
            gbi_pkg::ST_OUT: begin
                if (out_free) begin
                    state_next = gbi_pkg::ST_IDLE;
                end
            end
            default: state_next = gbi_pkg::ST_IDLE;
        endcase
    end

    // multiplier operands and sequencer outputs
    always_comb begin
        s_tready = 1'b0;
        mac_ctrl = '0;
        op_a     = '0;
        op_b     = '0;
        case (state_reg)
            gbi_pkg::ST_IDLE: begin
                s_tready = 1'b1;
            end
            gbi_pkg::ST_RANGE: begin
                op_a = {2'b00, dx[DW-1:0]};
                op_b = {1'b0, x_inv_step_reg};
            end
            gbi_pkg::ST_TX: begin
                op_a = {2'b00, dy[DW-1:0]};
                op_b = {1'b0, y_inv_step_reg};
            end
            gbi_pkg::ST_TY: begin
                mac_ctrl.acc_clr = 1'b1;
            end
            gbi_pkg::ST_WGT: begin
                op_a = gbi_pkg::MUL_A_W'(wx);
                op_b = gbi_pkg::MUL_B_W'(wy);
                // fold in the product of the previous corner
                mac_ctrl.acc_add = (k_reg != 2'd0);
            end
            gbi_pkg::ST_CELL: begin
                op_a = {1'b0, prod[32:0]};
                op_b = cell_ok_reg ? gbi_pkg::MUL_B_W'(rd_reg) : '0;
            end
            gbi_pkg::ST_SUM: begin
                mac_ctrl.acc_add = 1'b1;
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

    // grid memory
    always_ff @(posedge aclk) begin
        if (state_reg == gbi_pkg::ST_IDLE && s_acc && in_cmd == gbi_pkg::CMD_WRITE && wr_ok) begin
            mem[wr_addr] <= in_sample;
        end
        if (state_reg == gbi_pkg::ST_WGT && corner_ok) begin
            rd_reg <= mem[rd_addr];
        end
    end

    // control state and config
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= gbi_pkg::ST_IDLE;
            m_valid_reg    <= 1'b0;
            x_origin_reg   <= '0;
            x_end_reg      <= '0;
            x_inv_step_reg <= 32'd65536;
            y_origin_reg   <= '0;
            y_end_reg      <= '0;
            y_inv_step_reg <= 32'd65536;
            rows_used_reg  <= 7'd64;
            cols_used_reg  <= 7'd64;
            k_reg          <= '0;
        end else begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    gbi_pkg::REG_X_ORIGIN:   x_origin_reg   <= cfg_data;
                    gbi_pkg::REG_X_END:      x_end_reg      <= cfg_data;
                    gbi_pkg::REG_X_INV_STEP: x_inv_step_reg <= cfg_data;
                    gbi_pkg::REG_Y_ORIGIN:   y_origin_reg   <= cfg_data;
                    gbi_pkg::REG_Y_END:      y_end_reg      <= cfg_data;
                    gbi_pkg::REG_Y_INV_STEP: y_inv_step_reg <= cfg_data;
                    gbi_pkg::REG_ROWS_USED:  rows_used_reg  <= cfg_data[gbi_pkg::CNT_W-1:0];
                    gbi_pkg::REG_COLS_USED:  cols_used_reg  <= cfg_data[gbi_pkg::CNT_W-1:0];
                    default: ;
                endcase
            end
            if (state_reg == gbi_pkg::ST_TY) begin
                k_reg <= '0;
            end else if (state_reg == gbi_pkg::ST_CELL) begin
                k_reg <= k_reg + 2'd1;
            end
            if (state_reg == gbi_pkg::ST_OUT && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // query payload
    always_ff @(posedge aclk) begin
        case (state_reg)
            gbi_pkg::ST_IDLE: begin
                if (s_acc) begin
                    x_reg <= in_x;
                    y_reg <= in_y;
                end
            end
            gbi_pkg::ST_RANGE: begin
                y_lo_reg <= y_lo;
                y_hi_reg <= y_hi;
                res_reg  <= '0;
            end
            gbi_pkg::ST_TX: begin
                i_reg      <= prod[63:32];
                dt_reg     <= prod[31:16];
                offset_reg <= (y_lo_reg || y_hi_reg) ? y_ofs : '0;
            end
            gbi_pkg::ST_TY: begin
                if (y_out) begin
                    j_reg  <= y_lo_reg ? '0 : j_hi;
                    ds_reg <= '0;
                end else begin
                    j_reg  <= prod[63:32];
                    ds_reg <= prod[31:16];
                end
            end
            gbi_pkg::ST_WGT: begin
                cell_ok_reg <= corner_ok;
            end
            gbi_pkg::ST_RND: begin
                res_reg <= res_sum;
            end
            gbi_pkg::ST_OUT: begin
                if (out_free) begin
                    m_sat_reg <= sat_hi || sat_lo;
                    if (sat_hi) begin
                        m_value_reg <= 32'h7FFF_FFFF;
                    end else if (sat_lo) begin
                        m_value_reg <= 32'h8000_0000;
                    end else begin
                        m_value_reg <= res_reg[DW-1:0];
                    end
                end
            end
            default: ;
        endcase
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_value_reg;
    assign m_tuser  = m_sat_reg;

endmodule

`default_nettype wire

// ----- test/grid_bilinear_interpolator_test.sv -----
// self-checking stream testbench for the grid bilinear interpolator
`default_nettype none

module grid_bilinear_interpolator_test;

    localparam int GRID_ROWS = gbi_pkg::MAX_ROWS_DEF;
    localparam int GRID_COLS = gbi_pkg::MAX_COLS_DEF;

    typedef struct {
        logic               cmd;
        logic [5:0]         row;
        logic [5:0]         col;
        logic signed [31:0] sample;
        logic signed [31:0] x_coord;
        logic signed [31:0] y_coord;
    } grid_cmd_t;

    typedef struct {
        logic [31:0] value;
        logic        saturated;
    } grid_answer_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [gbi_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [gbi_pkg::DATA_W-1:0] cfg_data = '0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [gbi_pkg::S_TDATA_W-1:0] s_tdata = '0;
    logic s_tuser = 1'b0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [gbi_pkg::M_TDATA_W-1:0] m_tdata;
    logic m_tuser;

    // predictor copy of the settings, reset values
    logic signed [31:0] x_lo = 32'sd0;
    logic signed [31:0] x_hi = 32'sd0;
    logic [31:0]        x_inv = 32'h0001_0000;
    logic signed [31:0] y_lo = 32'sd0;
    logic signed [31:0] y_hi = 32'sd0;
    logic [31:0]        y_inv = 32'h0001_0000;
    logic [gbi_pkg::CNT_W-1:0] rows_set = 7'd64;
    logic [gbi_pkg::CNT_W-1:0] cols_set = 7'd64;

    logic signed [31:0] grid_mem [0:GRID_ROWS*GRID_COLS-1];
    bit                 loaded [0:GRID_ROWS*GRID_COLS-1];

    grid_cmd_t    queued_cmds [$];
    grid_answer_t pending_answers [$];
    grid_cmd_t    on_bus;
    bit           calm = 1'b0;
    int           mismatches = 0;

    grid_bilinear_interpolator dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always #2 aclk = ~aclk;

    function automatic int unsigned in_use(logic [gbi_pkg::CNT_W-1:0] n);
        return (n > GRID_ROWS) ? GRID_ROWS : n;
    endfunction

    // (c - origin) * inv as Q32.32, c not below origin
    function automatic logic [63:0] grid_pos(logic signed [31:0] c, logic signed [31:0] origin,
                                             logic [31:0] inv);
        logic signed [32:0] d;
        d = c - origin;
        return {31'b0, d[32:0]} * {32'b0, inv};
    endfunction

    function automatic logic signed [31:0] sample_at(logic [63:0] i, logic [63:0] j);
        if (i >= in_use(rows_set) || j >= in_use(cols_set))
            return 32'sd0;
        return grid_mem[{i[5:0], j[5:0]}];
    endfunction

    function automatic logic signed [95:0] weigh(logic [33:0] w, logic signed [31:0] s);
        logic signed [95:0] a;
        logic signed [95:0] b;
        a = w;
        b = s;
        return a * b;
    endfunction

    function automatic grid_answer_t interpolate(logic signed [31:0] x, logic signed [31:0] y);
        grid_answer_t r;
        logic [63:0] tx, ty, i, j;
        logic [33:0] ax, bx, ay, by;
        logic signed [95:0] acc, val;
        int unsigned nc;
        val = '0;
        if (x >= x_lo && x <= x_hi) begin
            tx = grid_pos(x, x_lo, x_inv);
            i = {32'b0, tx[63:32]};
            bx = {18'b0, tx[31:16]};
            ax = 34'h1_0000 - bx;
            if (y < y_lo || y > y_hi) begin
                // off the grid in y: x interpolation on the edge column plus raw offset
                nc = in_use(cols_set);
                if (y < y_lo)
                    j = 64'd0;
                else
                    j = (nc == 0) ? 64'(GRID_COLS) : 64'(nc - 1);
                acc = weigh(ax, sample_at(i, j)) + weigh(bx, sample_at(i + 1, j));
                val = (acc + 96'sh8000) >>> 16;
                if (y < y_lo)
                    val = val + y - y_lo;
                else
                    val = val + y - y_hi;
            end else begin
                ty = grid_pos(y, y_lo, y_inv);
                j = {32'b0, ty[63:32]};
                by = {18'b0, ty[31:16]};
                ay = 34'h1_0000 - by;
                acc = weigh(ax * ay, sample_at(i, j)) + weigh(ax * by, sample_at(i, j + 1))
                    + weigh(bx * ay, sample_at(i + 1, j))
                    + weigh(bx * by, sample_at(i + 1, j + 1));
                val = (acc + 96'sh8000_0000) >>> 32;
            end
        end
        if (val > 96'sd2147483647) begin
            r.value = 32'h7FFF_FFFF;
            r.saturated = 1'b1;
        end else if (val < -96'sd2147483648) begin
            r.value = 32'h8000_0000;
            r.saturated = 1'b1;
        end else begin
            r.value = val[31:0];
            r.saturated = 1'b0;
        end
        return r;
    endfunction

    function automatic void apply_transfer(grid_cmd_t c);
        if (c.cmd == gbi_pkg::CMD_WRITE)
            grid_mem[{c.row, c.col}] = c.sample;
        else
            pending_answers.push_back(interpolate(c.x_coord, c.y_coord));
    endfunction

    // input side
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready)
                apply_transfer(on_bus);
            if (!s_tvalid || s_tready) begin
                if (queued_cmds.size() != 0 && (calm || $urandom_range(99) >= 12)) begin
                    on_bus = queued_cmds.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser <= on_bus.cmd;
                    s_tdata <= {{(gbi_pkg::S_TDATA_W - 108){1'b0}}, on_bus.y_coord,
                                on_bus.x_coord, on_bus.sample, on_bus.col, on_bus.row};
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // result side
    always @(posedge aclk) begin
        grid_answer_t want;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (pending_answers.size() == 0) begin
                    mismatches++;
                    $display("%0t: result transfer with none outstanding: expected none, actual %h/%b",
                             $time, m_tdata, m_tuser);
                end else begin
                    want = pending_answers.pop_front();
                    if (m_tdata !== want.value) begin
                        mismatches++;
                        $display("%0t: value expected %h actual %h", $time, want.value, m_tdata);
                    end
                    if (m_tuser !== want.saturated) begin
                        mismatches++;
                        $display("%0t: saturated expected %b actual %b", $time, want.saturated,
                                 m_tuser);
                    end
                end
            end
            m_tready <= calm || ($urandom_range(99) >= 12);
        end
    end

    task automatic write_reg(input logic [gbi_pkg::CFG_IDX_W-1:0] idx, input logic [31:0] data);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        case (idx)
            gbi_pkg::REG_X_ORIGIN:   x_lo = data;
            gbi_pkg::REG_X_END:      x_hi = data;
            gbi_pkg::REG_X_INV_STEP: x_inv = data;
            gbi_pkg::REG_Y_ORIGIN:   y_lo = data;
            gbi_pkg::REG_Y_END:      y_hi = data;
            gbi_pkg::REG_Y_INV_STEP: y_inv = data;
            gbi_pkg::REG_ROWS_USED:  rows_set = data[gbi_pkg::CNT_W-1:0];
            gbi_pkg::REG_COLS_USED:  cols_set = data[gbi_pkg::CNT_W-1:0];
            default: ;
        endcase
    endtask

    // wait until nothing is in flight, then let a write or query finish inside
    task automatic drain();
        @(negedge aclk);
        while (queued_cmds.size() != 0 || s_tvalid || pending_answers.size() != 0)
            @(negedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    function automatic grid_cmd_t noise_cmd();
        grid_cmd_t c;
        c.cmd = gbi_pkg::CMD_WRITE;
        c.row = 6'($urandom);
        c.col = 6'($urandom);
        c.sample = $urandom;
        c.x_coord = $urandom;
        c.y_coord = $urandom;
        return c;
    endfunction

    function automatic logic [31:0] fresh_sample();
        case ($urandom_range(19))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            default: return $urandom;
        endcase
    endfunction

    function automatic void push_write(logic [5:0] row, logic [5:0] col, logic [31:0] sample);
        grid_cmd_t c;
        c = noise_cmd();
        c.cmd = gbi_pkg::CMD_WRITE;
        c.row = row;
        c.col = col;
        c.sample = sample;
        loaded[{row, col}] = 1'b1;
        queued_cmds.push_back(c);
    endfunction

    function automatic void ensure_loaded(logic [63:0] i, logic [63:0] j);
        if (i < in_use(rows_set) && j < in_use(cols_set) && !loaded[{i[5:0], j[5:0]}])
            push_write(i[5:0], j[5:0], fresh_sample());
    endfunction

    // every in-use neighbour a query may touch gets written first
    function automatic void push_query(logic signed [31:0] x, logic signed [31:0] y);
        grid_cmd_t c;
        logic [63:0] i, j;
        int unsigned nc;
        if (x >= x_lo && x <= x_hi) begin
            i = grid_pos(x, x_lo, x_inv) >> 32;
            nc = in_use(cols_set);
            if (y < y_lo)
                j = 64'd0;
            else if (y > y_hi)
                j = (nc == 0) ? 64'(GRID_COLS) : 64'(nc - 1);
            else
                j = grid_pos(y, y_lo, y_inv) >> 32;
            ensure_loaded(i, j);
            ensure_loaded(i + 1, j);
            ensure_loaded(i, j + 1);
            ensure_loaded(i + 1, j + 1);
        end
        c = noise_cmd();
        c.cmd = gbi_pkg::CMD_QUERY;
        c.x_coord = x;
        c.y_coord = y;
        queued_cmds.push_back(c);
    endfunction

    // mostly inside the range, some at and just past the bounds, some anywhere
    function automatic logic signed [31:0] pick_coord(logic signed [31:0] lo,
                                                       logic signed [31:0] hi);
        longint span;
        longint unsigned pick;
        int unsigned roll;
        roll = $urandom_range(99);
        span = longint'(hi) - longint'(lo);
        pick = {$urandom, $urandom};
        if (roll < 65 && span >= 0) begin
            pick = pick % (span + 1);
            return lo + pick[31:0];
        end
        if (roll < 80) begin
            case ($urandom_range(3))
                0: return lo;
                1: return hi;
                2: return lo - 1;
                default: return hi + 1;
            endcase
        end
        if (roll < 90)
            return $urandom_range(1) ? lo - $urandom_range(32'h2_0000) : hi + $urandom_range(32'h2_0000);
        return $urandom;
    endfunction

    function automatic int axis_points(logic [gbi_pkg::CNT_W-1:0] n);
        return (n == 0) ? 1 : ((n > GRID_ROWS) ? GRID_ROWS : n);
    endfunction

    task automatic lay_axis(input int n, output logic [31:0] lo, output logic [31:0] hi,
                            output logic [31:0] inv);
        int unsigned stride;
        longint top;
        stride = $urandom_range(32'h4_0000, 2);
        lo = $urandom_range(32'h2000_0000) - 32'h1000_0000;
        top = longint'($signed(lo)) + longint'(n - 1) * longint'(stride);
        hi = top[31:0];
        inv = 32'(64'h1_0000_0000 / stride);
    endtask

    task automatic configure(input int k);
        logic [31:0] xo, xe, xi, yo, ye, yi, swap;
        logic [gbi_pkg::CNT_W-1:0] nr, nc;
        case (k)
            0: begin nr = 7'd64; nc = 7'd64; end
            1: begin nr = 7'd1; nc = 7'd1; end
            2: begin nr = 7'd2; nc = 7'd64; end
            3: begin nr = 7'd0; nc = 7'd100; end
            4: begin nr = 7'd8; nc = 7'd8; end
            5: begin nr = 7'd64; nc = 7'd64; end
            6: begin nr = 7'd127; nc = 7'd0; end
            7: begin nr = 7'd100; nc = 7'd127; end
            default: begin
                nr = 7'($urandom_range(64, 1));
                nc = 7'($urandom_range(64, 1));
            end
        endcase
        lay_axis(axis_points(nr), xo, xe, xi);
        lay_axis(axis_points(nc), yo, ye, yi);
        if (k == 4) begin
            // empty x range
            swap = xo;
            xo = xe;
            xe = swap;
        end
        if (k == 5) begin
            // widest bounds with spacing that does not match them
            xo = 32'h8000_0000;
            xe = 32'h7FFF_FFFF;
            xi = 32'h0;
            yo = 32'h8000_0000;
            ye = 32'h7FFF_FFFF;
            yi = 32'hFFFF_FFFF;
        end
        write_reg(gbi_pkg::REG_X_ORIGIN, xo);
        write_reg(gbi_pkg::REG_X_END, xe);
        write_reg(gbi_pkg::REG_X_INV_STEP, xi);
        write_reg(gbi_pkg::REG_Y_ORIGIN, yo);
        write_reg(gbi_pkg::REG_Y_END, ye);
        write_reg(gbi_pkg::REG_Y_INV_STEP, yi);
        write_reg(gbi_pkg::REG_ROWS_USED, {25'b0, nr});
        write_reg(gbi_pkg::REG_COLS_USED, {25'b0, nc});
    endtask

    task automatic random_phase(input int count);
        repeat (count) begin
            if ($urandom_range(99) < 25)
                push_write(6'($urandom), 6'($urandom), fresh_sample());
            else
                push_query(pick_coord(x_lo, x_hi), pick_coord(y_lo, y_hi));
        end
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // settings out of reset: x range is the single point zero
        push_query(32'sd0, 32'sd0);
        push_query(32'sd0, 32'h0001_8000);
        drain();

        // 4 x 3 grid, x from -2.0 step 1.0, y from 0 step 0.5
        write_reg(gbi_pkg::REG_X_ORIGIN, 32'hFFFE_0000);
        write_reg(gbi_pkg::REG_X_END, 32'h0001_0000);
        write_reg(gbi_pkg::REG_X_INV_STEP, 32'h0001_0000);
        write_reg(gbi_pkg::REG_Y_ORIGIN, 32'h0);
        write_reg(gbi_pkg::REG_Y_END, 32'h0001_0000);
        write_reg(gbi_pkg::REG_Y_INV_STEP, 32'h0002_0000);
        write_reg(gbi_pkg::REG_ROWS_USED, 32'd4);
        write_reg(gbi_pkg::REG_COLS_USED, 32'd3);
        push_write(6'd0, 6'd0, 32'h8000_0000);
        push_write(6'd0, 6'd2, 32'h7FFF_FFFF);
        push_write(6'd63, 6'd63, 32'h0);
        push_query(x_lo, y_lo);
        push_query(x_hi, y_hi);
        push_query(x_lo - 1, 32'sd0);
        push_query(x_hi + 1, 32'sd0);
        push_query(32'h8000_0000, 32'sd0);
        push_query(32'h7FFF_FFFF, 32'sd0);
        // far above and below the grid: offset drives the sum past 32 bits
        push_query(x_lo, 32'h7FFF_FFFF);
        push_query(x_lo, 32'h8000_0000);
        push_query(32'hFFFF_C000, y_lo - 1);
        push_query(32'h0000_8000, y_hi + 1);
        push_query(32'hFFFF_4000, 32'h0000_6000);
        drain();

        // neighbour loads add roughly as many writes again
        for (int k = 0; k < 10; k++) begin
            calm = (k == 2);
            configure(k);
            random_phase(60);
            drain();
        end
        calm = 1'b0;

        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        #4_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

`default_nettype wire
